// ===== rtl/core/imh_pkg.sv =====
package imh_pkg;
	localparam int MAX_NODES = 1024;
	localparam int KEY_WIDTH = 32;
	localparam int SLOT_W = $clog2(MAX_NODES);
	localparam int CNT_W = $clog2(MAX_NODES + 1);
	localparam int NODE_W = 10;
	localparam int KEYIN_W = 32;
	localparam logic [SLOT_W-1:0] ROOT_SLOT = '0;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_DECREASE = 2'd2,
		CMD_QUERY = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_EMPTY = 3'd1,
		ST_FULL = 3'd2,
		ST_PRESENT = 3'd3,
		ST_IGNORED = 3'd4
	} status_t;

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic [KEY_WIDTH-1:0] key;
	} entry_t;

	// swap request from the sequencer to the heap store
	typedef struct packed {
		logic wr_a;
		logic wr_b;
		logic [SLOT_W-1:0] addr_a;
		logic [SLOT_W-1:0] addr_b;
		entry_t data_a;
		entry_t data_b;
	} hwr_t;
endpackage

// ===== rtl/core/indexed_min_heap_unit.sv =====
// Indexed binary min-heap with decrease-key.
// Flow: a query or a rejected command passes S_LOOK, S_DECIDE, S_ROOT, S_RES
// and S_OUT; a decrease waits in S_DECIDE once more for its key read; each sift
// level is a pair read (S_RD) then a compare/swap (S_CMP), over at most 10 levels.
// Throughput: one request at a time; in_stall is high while a command runs.
// Reset: arst_n clears fill count and control, then a clearing pass marks
// every node absent (in_stall high); heap contents need no clearing.
module indexed_min_heap_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] cmd,
	input logic [imh_pkg::NODE_W-1:0] node_id,
	input logic [imh_pkg::KEYIN_W-1:0] key_value,
	output logic out_valid,
	input logic out_stall,
	output logic [imh_pkg::NODE_W-1:0] out_node,
	output logic [imh_pkg::KEYIN_W-1:0] out_key,
	output logic [imh_pkg::CNT_W-1:0] entry_count,
	output logic is_empty,
	output logic is_member,
	output logic [2:0] status
);
	import imh_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE = 9'b0_0000_0001,
		S_LOOK = 9'b0_0000_0010,  // map and root reads in flight
		S_DECIDE = 9'b0_0000_0100,
		S_RD = 9'b0_0000_1000,    // pair read issued
		S_CMP = 9'b0_0001_0000,   // compare and swap
		S_ROOT = 9'b0_0010_0000,  // root read for result
		S_RES = 9'b0_0100_0000,
		S_OUT = 9'b0_1000_0000,
		S_INIT = 9'b1_0000_0000   // position map clearing pass
	} state_t;

	state_t state_q;
	cmd_t cmd_q;
	logic [NODE_W-1:0] node_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [CNT_W-1:0] fill_q;
	logic [SLOT_W-1:0] s_q;
	logic up_q;
	logic removed_q;
	entry_t rem_q;
	status_t st_q;
	logic dec_wait_q;
	logic [NODE_W-1:0] init_q;

	logic [SLOT_W-1:0] rd_a, rd_b;
	entry_t q_a, q_b;
	hwr_t wr;
	logic [SLOT_W-1:0] pm_slot;
	logic pm_present;
	logic pm_wa, pm_wb, pm_pa;
	logic [NODE_W-1:0] pm_na, pm_nb;
	logic [SLOT_W-1:0] pm_sa, pm_sb;

	// walk addresses: a is the current slot, b parent or a child
	logic [SLOT_W:0] lch, rch;
	logic [SLOT_W-1:0] par;
	logic swap, has_r, pick_r;
	logic [SLOT_W-1:0] other;
	logic in_range;

	assign in_range = ({1'b0, node_q} < (NODE_W+1)'(MAX_NODES));
	assign lch = {s_q, 1'b1};
	assign rch = lch + 1'b1;
	assign par = SLOT_W'((s_q - 1'b1) >> 1);

	// q_a holds slot s (up) or the right child (down), q_b the parent (up) or the
	// left child (down); down reads both children at once, left into q_b and
	// right into q_a, with the walking entry in cur
	entry_t cur_q;

	always_comb begin
		has_r = ({1'b0, rch} < {1'b0, fill_q});
		pick_r = has_r && !(q_b.key < q_a.key);
		if (up_q) begin
			other = par;
			swap = (cur_q.key < q_b.key);
		end else begin
			other = pick_r ? SLOT_W'(rch) : SLOT_W'(lch);
			swap = pick_r ? (cur_q.key > q_a.key) : (cur_q.key > q_b.key);
		end
	end

	always_comb begin
		rd_a = s_q;
		rd_b = s_q;
		case (state_q)
			S_IDLE: begin
				rd_a = ROOT_SLOT;
				rd_b = SLOT_W'(fill_q - 1'b1);
			end
			S_DECIDE, S_CMP: begin
				rd_a = s_q;
				rd_b = s_q;
			end
			S_RD: begin
				rd_a = up_q ? s_q : SLOT_W'(rch);
				rd_b = up_q ? par : SLOT_W'(lch);
			end
			default: begin
				rd_a = ROOT_SLOT;
				rd_b = ROOT_SLOT;
			end
		endcase
	end

	imh_heap_ram u_ram (
		.clk(clk), .rd_a(rd_a), .rd_b(rd_b), .wr(wr), .q_a(q_a), .q_b(q_b)
	);

	imh_pos_map u_map (
		.clk(clk), .rd_node(state_q == S_IDLE ? node_id : node_q),
		.wr_a(pm_wa), .wr_node_a(pm_na), .wr_slot_a(pm_sa), .wr_pres_a(pm_pa),
		.wr_b(pm_wb), .wr_node_b(pm_nb), .wr_slot_b(pm_sb),
		.rd_slot(pm_slot), .rd_present(pm_present)
	);

	logic walk_ok;
	assign walk_ok = up_q ? (s_q != ROOT_SLOT) : (lch < fill_q);

	always_comb begin
		wr = '0;
		pm_wa = 1'b0; pm_wb = 1'b0; pm_pa = 1'b1;
		pm_na = cur_q.node; pm_sa = s_q;
		pm_nb = cur_q.node; pm_sb = s_q;
		if (state_q == S_INIT) begin
			// clearing pass: one node marked absent per cycle
			pm_wa = 1'b1; pm_na = init_q; pm_sa = ROOT_SLOT; pm_pa = 1'b0;
		end
		if (state_q == S_CMP && swap) begin
			wr.wr_a = 1'b1; wr.addr_a = s_q;
			wr.data_a = up_q ? q_b : (pick_r ? q_a : q_b);
			wr.wr_b = 1'b1; wr.addr_b = other; wr.data_b = cur_q;
			// both entries keep their present bit; remap only
			pm_wa = 1'b1; pm_na = cur_q.node; pm_sa = other;
			pm_wb = 1'b1; pm_nb = wr.data_a.node; pm_sb = s_q;
		end
		if (state_q == S_DECIDE && !dec_wait_q) begin
			case (cmd_q)
				CMD_INSERT: if (st_q == ST_OK) begin
					wr.wr_a = 1'b1; wr.addr_a = s_q;
					wr.data_a = '{node: node_q, key: key_q};
					pm_wa = 1'b1; pm_na = node_q; pm_sa = s_q;
				end
				CMD_REMOVE: if (st_q == ST_OK) begin
					pm_wa = 1'b1; pm_na = rem_q.node; pm_pa = 1'b0;
					// last entry moves to the root unless it was the removed one
					if (fill_q > CNT_W'(1)) begin
						wr.wr_a = 1'b1; wr.addr_a = ROOT_SLOT; wr.data_a = cur_q;
						pm_wb = 1'b1; pm_nb = cur_q.node; pm_sb = ROOT_SLOT;
					end
				end
				CMD_DECREASE: if (st_q == ST_OK && key_q < q_a.key) begin
					wr.wr_a = 1'b1; wr.addr_a = s_q;
					wr.data_a = '{node: node_q, key: key_q};
				end
				default: ;
			endcase
		end
	end

	// look step: map read and root/last read results are valid
	logic [SLOT_W-1:0] dslot;
	assign dslot = pm_slot;

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (in_valid) begin
				cmd_q <= cmd_t'(cmd);
				node_q <= node_id;
				key_q <= KEY_WIDTH'(key_value);
				removed_q <= 1'b0;
			end
			S_LOOK: begin
				rem_q <= q_a;
				case (cmd_q)
					CMD_INSERT: begin
						up_q <= 1'b1;
						s_q <= SLOT_W'(fill_q);
						cur_q <= '{node: node_q, key: key_q};
						if (!in_range) st_q <= ST_FULL;
						else if (pm_present) st_q <= ST_PRESENT;
						else if (fill_q >= CNT_W'(MAX_NODES)) st_q <= ST_FULL;
						else st_q <= ST_OK;
					end
					CMD_REMOVE: begin
						up_q <= 1'b0;
						s_q <= ROOT_SLOT;
						cur_q <= q_b;
						st_q <= (fill_q == '0) ? ST_EMPTY : ST_OK;
					end
					CMD_DECREASE: begin
						up_q <= 1'b1;
						s_q <= dslot;
						cur_q <= '{node: node_q, key: key_q};
						st_q <= (in_range && pm_present) ? ST_OK : ST_IGNORED;
					end
					default: st_q <= ST_OK;
				endcase
			end
			S_DECIDE: ;
			S_CMP: if (swap) s_q <= other;
			default: ;
		endcase
		if (state_q == S_DECIDE && !dec_wait_q && cmd_q == CMD_DECREASE
			&& st_q == ST_OK && !(key_q < q_a.key))
			st_q <= ST_IGNORED;
		if (state_q == S_DECIDE && cmd_q == CMD_REMOVE && st_q == ST_OK)
			removed_q <= 1'b1;
		if (state_q == S_RES) begin
			out_node <= removed_q ? rem_q.node : (fill_q == '0 ? '0 : q_a.node);
			out_key <= KEYIN_W'(removed_q ? rem_q.key : (fill_q == '0 ? '0 : q_a.key));
			entry_count <= fill_q;
			is_empty <= (fill_q == '0);
			is_member <= in_range && pm_present;
			status <= st_q;
		end
	end

	// decrease needs the current key at the mapped slot: S_DECIDE reads it
	// (q_a holds slot s on the repeated S_DECIDE pass); insert and remove decide at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			fill_q <= '0;
			dec_wait_q <= 1'b0;
			init_q <= '0;
		end else begin
			case (state_q)
				S_INIT: begin
					init_q <= init_q + 1'b1;
					if (init_q == NODE_W'(MAX_NODES - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (in_valid) state_q <= S_LOOK;
				S_LOOK: begin
					dec_wait_q <= (cmd_q == CMD_DECREASE);
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (dec_wait_q) begin
						dec_wait_q <= 1'b0;
						state_q <= S_DECIDE;
					end else if (st_q != ST_OK || cmd_q == CMD_QUERY) begin
						state_q <= S_ROOT;
					end else begin
						if (cmd_q == CMD_INSERT) fill_q <= fill_q + 1'b1;
						if (cmd_q == CMD_REMOVE) fill_q <= fill_q - 1'b1;
						if (cmd_q == CMD_DECREASE && !(key_q < q_a.key))
							state_q <= S_ROOT;
						else if (cmd_q == CMD_REMOVE && fill_q == CNT_W'(1))
							state_q <= S_ROOT;
						else
							state_q <= S_RD;
					end
				end
				S_RD: state_q <= walk_ok ? S_CMP : S_ROOT;
				S_CMP: state_q <= (swap && (up_q ? other != ROOT_SLOT : 1'b1))
					? S_RD : S_ROOT;
				S_ROOT: state_q <= S_RES;
				S_RES: state_q <= S_OUT;
				S_OUT: if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
endmodule

// ===== rtl/core/imh_heap_ram.sv =====
module imh_heap_ram (
	input logic clk,
	input logic [imh_pkg::SLOT_W-1:0] rd_a,
	input logic [imh_pkg::SLOT_W-1:0] rd_b,
	input imh_pkg::hwr_t wr,
	output imh_pkg::entry_t q_a,
	output imh_pkg::entry_t q_b
);
	import imh_pkg::*;

	entry_t mem [MAX_NODES];

	always_ff @(posedge clk) begin
		if (wr.wr_a) mem[wr.addr_a] <= wr.data_a;
		if (wr.wr_b) mem[wr.addr_b] <= wr.data_b;
		q_a <= mem[rd_a];
		q_b <= mem[rd_b];
	end
endmodule

// ===== rtl/core/imh_pos_map.sv =====
module imh_pos_map (
	input logic clk,
	input logic [imh_pkg::NODE_W-1:0] rd_node,
	input logic wr_a,
	input logic [imh_pkg::NODE_W-1:0] wr_node_a,
	input logic [imh_pkg::SLOT_W-1:0] wr_slot_a,
	input logic wr_pres_a,
	input logic wr_b,
	input logic [imh_pkg::NODE_W-1:0] wr_node_b,
	input logic [imh_pkg::SLOT_W-1:0] wr_slot_b,
	output logic [imh_pkg::SLOT_W-1:0] rd_slot,
	output logic rd_present
);
	import imh_pkg::*;

	// present flag on top of the slot; port b only remaps present nodes
	logic [SLOT_W:0] slot_mem [MAX_NODES];

	always_ff @(posedge clk) begin
		if (wr_a) slot_mem[wr_node_a] <= {wr_pres_a, wr_slot_a};
		if (wr_b) slot_mem[wr_node_b] <= {1'b1, wr_slot_b};
		{rd_present, rd_slot} <= slot_mem[rd_node];
	end
endmodule

// ===== rtl/core/imh_checker.sv =====
module imh_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [imh_pkg::CNT_W-1:0] entry_count,
	input logic is_empty,
	input logic [2:0] status
);
	import imh_pkg::*;

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (entry_count == '0)))
		else $error("empty flag mismatch");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> is_empty)
		else $error("empty status with entries");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("accepting while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(entry_count))
		else $error("stalled result changed");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted without going busy");
endmodule

bind indexed_min_heap_unit imh_checker u_imh_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .entry_count(entry_count),
	.is_empty(is_empty), .status(status)
);

// ===== dv/indexed_min_heap_unit_tb.sv =====
module indexed_min_heap_unit_tb;
	import imh_pkg::*;

	// one result of the heap, as the block reports it
	typedef struct {
		logic [NODE_W-1:0] node;
		logic [KEYIN_W-1:0] key;
		logic [CNT_W-1:0] count;
		logic empty;
		logic member;
		logic [2:0] stat;
	} heap_resp_t;

	// Scoreboard: mirror of the heap plus the queue of pending responses.
	class heap_scoreboard;
		logic [NODE_W-1:0] slot_node [MAX_NODES];
		logic [KEY_WIDTH-1:0] slot_key [MAX_NODES];
		int slot_of [MAX_NODES];
		bit present [MAX_NODES];
		int fill;
		heap_resp_t pending [$];
		int errors;
		int checked;

		function new();
			fill = 0;
			errors = 0;
			checked = 0;
			foreach (present[i]) present[i] = 0;
		endfunction

		function void swap_slots(int a, int b);
			logic [NODE_W-1:0] tn;
			logic [KEY_WIDTH-1:0] tk;
			tn = slot_node[a];
			tk = slot_key[a];
			slot_node[a] = slot_node[b];
			slot_key[a] = slot_key[b];
			slot_node[b] = tn;
			slot_key[b] = tk;
			slot_of[slot_node[a]] = a;
			slot_of[slot_node[b]] = b;
		endfunction

		function void bubble_up(int s);
			int p;
			while (s != 0) begin
				p = (s - 1) / 2;
				if (!(slot_key[s] < slot_key[p])) break;
				swap_slots(s, p);
				s = p;
			end
		endfunction

		function void bubble_down(int s);
			int l, r, c;
			forever begin
				l = 2 * s + 1;
				r = l + 1;
				if (l >= fill) break;
				if (r >= fill) c = l;
				else c = (slot_key[l] < slot_key[r]) ? l : r;
				if (!(slot_key[s] > slot_key[c])) break;
				swap_slots(s, c);
				s = c;
			end
		endfunction

		// apply one accepted request and queue the response it must give
		function void note_request(cmd_t op, logic [NODE_W-1:0] nd, logic [KEYIN_W-1:0] kv);
			heap_resp_t r;
			status_t st;
			bit removed;
			int s;
			st = ST_OK;
			removed = 0;
			r.node = '0;
			r.key = '0;
			case (op)
				CMD_INSERT: begin
					if (present[nd]) st = ST_PRESENT;
					else if (fill >= MAX_NODES) st = ST_FULL;
					else begin
						slot_node[fill] = nd;
						slot_key[fill] = kv;
						slot_of[nd] = fill;
						present[nd] = 1;
						fill++;
						bubble_up(fill - 1);
					end
				end
				CMD_REMOVE: begin
					if (fill == 0) st = ST_EMPTY;
					else begin
						removed = 1;
						r.node = slot_node[0];
						r.key = slot_key[0];
						present[slot_node[0]] = 0;
						fill--;
						if (fill > 0) begin
							slot_node[0] = slot_node[fill];
							slot_key[0] = slot_key[fill];
							slot_of[slot_node[0]] = 0;
							bubble_down(0);
						end
					end
				end
				CMD_DECREASE: begin
					if (!present[nd]) st = ST_IGNORED;
					else begin
						s = slot_of[nd];
						if (s >= fill || !(kv < slot_key[s])) st = ST_IGNORED;
						else begin
							slot_key[s] = kv;
							bubble_up(s);
						end
					end
				end
				default: ;
			endcase
			if (!removed && fill > 0) begin
				r.node = slot_node[0];
				r.key = slot_key[0];
			end
			r.count = CNT_W'(fill);
			r.empty = (fill == 0);
			r.member = present[nd];
			r.stat = st;
			pending.insert(pending.size(), r);
		endfunction

		function void check_response(heap_resp_t got);
			heap_resp_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected response node=%0d key=%0h", $time, got.node, got.key);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (got.node !== e.node) begin
				$display("%0t: out_node exp %0d got %0d", $time, e.node, got.node);
				errors++;
			end
			if (got.key !== e.key) begin
				$display("%0t: out_key exp %0h got %0h", $time, e.key, got.key);
				errors++;
			end
			if (got.count !== e.count) begin
				$display("%0t: entry_count exp %0d got %0d", $time, e.count, got.count);
				errors++;
			end
			if (got.empty !== e.empty) begin
				$display("%0t: is_empty exp %0b got %0b", $time, e.empty, got.empty);
				errors++;
			end
			if (got.member !== e.member) begin
				$display("%0t: is_member exp %0b got %0b", $time, e.member, got.member);
				errors++;
			end
			if (got.stat !== e.stat) begin
				$display("%0t: status exp %0d got %0d", $time, e.stat, got.stat);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [1:0] cmd;
	logic [NODE_W-1:0] node_id;
	logic [KEYIN_W-1:0] key_value;
	logic out_valid;
	logic out_stall;
	logic [NODE_W-1:0] out_node;
	logic [KEYIN_W-1:0] out_key;
	logic [CNT_W-1:0] entry_count;
	logic is_empty;
	logic is_member;
	logic [2:0] status;

	heap_scoreboard sb;
	int send_idle_pct;	// chance per cycle that the sender holds back
	int recv_stall_pct;	// chance per cycle that the receiver stalls
	int quiet_cycles;	// watchdog: cycles with no handshake on either side
	int n_req;
	int n_ins, n_rem, n_dec, n_qry;
	localparam int WATCHDOG = 20000;

	indexed_min_heap_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.node_id(node_id),
		.key_value(key_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_node(out_node),
		.out_key(out_key),
		.entry_count(entry_count),
		.is_empty(is_empty),
		.is_member(is_member),
		.status(status)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Response side: sample at the rising edge, pick the next stall at the falling edge.
	always @(posedge clk) begin
		heap_resp_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.node = out_node;
			got.key = out_key;
			got.count = entry_count;
			got.empty = is_empty;
			got.member = is_member;
			got.stat = status;
			sb.check_response(got);
		end
	end

	always @(negedge clk) begin
		if (arst_n)
			out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Watchdog on handshake progress.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("%0t: watchdog expired, %0d responses pending", $time, sb.pending.size());
			$display("indexed_min_heap_unit_tb: FAIL");
			$finish;
		end
	end

	// Drive one request: optional idle gap, then hold it until accepted.
	task automatic send_request(cmd_t op, logic [NODE_W-1:0] nd, logic [KEYIN_W-1:0] kv);
		while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		in_valid = 1'b1;
		cmd = op;
		node_id = nd;
		key_value = kv;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(op, nd, kv);
		n_req++;
		case (op)
			CMD_INSERT: n_ins++;
			CMD_REMOVE: n_rem++;
			CMD_DECREASE: n_dec++;
			default: n_qry++;
		endcase
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.pending.size() != 0) @(negedge clk);
	endtask

	// Pick a node biased toward those in the heap, so decreases and
	// duplicate inserts land often.
	function automatic logic [NODE_W-1:0] pick_node(int span);
		if (sb.fill > 0 && $urandom_range(1))
			return sb.slot_node[$urandom_range(sb.fill - 1)];
		return NODE_W'($urandom_range(span - 1));
	endfunction

	// Random phase: keys are mostly drawn from a narrow range so that
	// equal keys and tie breaks in the sift are common.
	task automatic random_phase(int items, int span);
		int p;
		cmd_t op;
		logic [NODE_W-1:0] nd;
		logic [KEYIN_W-1:0] kv;
		for (int i = 0; i < items; i++) begin
			p = $urandom_range(99);
			if (p < 40) op = CMD_INSERT;
			else if (p < 65) op = CMD_REMOVE;
			else if (p < 85) op = CMD_DECREASE;
			else op = CMD_QUERY;
			nd = pick_node(span);
			case ($urandom_range(2))
				0: kv = $urandom_range(15);
				1: kv = $urandom;
				default: kv = (op == CMD_DECREASE && sb.present[nd])
					? sb.slot_key[sb.slot_of[nd]] - $urandom_range(3) : $urandom_range(255);
			endcase
			send_request(op, nd, kv);
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_QUERY;
		node_id = '0;
		key_value = '0;
		out_stall = 1'b0;
		send_idle_pct = 25;
		recv_stall_pct = 53;
		n_req = 0;
		n_ins = 0;
		n_rem = 0;
		n_dec = 0;
		n_qry = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty heap behavior, extremes, duplicates, ties, decreases.
		send_request(CMD_REMOVE, 10'd0, 32'd0);
		send_request(CMD_QUERY, 10'd1023, 32'hFFFF_FFFF);
		send_request(CMD_DECREASE, 10'd5, 32'd0);
		send_request(CMD_INSERT, 10'd1023, 32'hFFFF_FFFF);
		send_request(CMD_INSERT, 10'd1023, 32'd1);
		send_request(CMD_INSERT, 10'd0, 32'd0);
		send_request(CMD_INSERT, 10'd512, 32'd7);
		send_request(CMD_INSERT, 10'd513, 32'd7);
		send_request(CMD_INSERT, 10'd341, 32'd7);
		send_request(CMD_INSERT, 10'd682, 32'hAAAA_5555);
		send_request(CMD_DECREASE, 10'd512, 32'd7);
		send_request(CMD_DECREASE, 10'd682, 32'h5555_AAAA);
		send_request(CMD_DECREASE, 10'd1023, 32'd0);
		send_request(CMD_QUERY, 10'd1023, 32'd0);
		send_request(CMD_REMOVE, 10'd0, 32'd0);
		send_request(CMD_REMOVE, 10'd0, 32'd0);
		send_request(CMD_REMOVE, 10'd0, 32'd0);
		send_request(CMD_QUERY, 10'd0, 32'd0);
		send_request(CMD_REMOVE, 10'd0, 32'd0);
		send_request(CMD_REMOVE, 10'd0, 32'd0);
		send_request(CMD_REMOVE, 10'd0, 32'd0);
		send_request(CMD_REMOVE, 10'd0, 32'd0);
		send_request(CMD_QUERY, 10'd513, 32'd0);
		// hold off until the heap has answered everything
		wait_drained();

		random_phase(120, 64);
		send_idle_pct = 53;
		recv_stall_pct = 25;
		random_phase(120, 1024);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_phase(40, 128);

		// insert every absent node to reach a count of 1024, then drain partway
		for (int n = 0; n < MAX_NODES; n++)
			if (!sb.present[n]) send_request(CMD_INSERT, NODE_W'(n), $urandom);
		send_request(CMD_INSERT, pick_node(1024), 32'd3);
		send_request(CMD_QUERY, pick_node(1024), 32'd0);
		repeat (20) send_request(CMD_REMOVE, 10'd0, 32'd0);

		wait_drained();
		repeat (40) @(posedge clk);
		$display("covered %0d requests: %0d insert, %0d remove, %0d decrease, %0d query",
			n_req, n_ins, n_rem, n_dec, n_qry);
		$display("%0d responses checked, heap filled to capacity once", sb.checked);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("indexed_min_heap_unit_tb: PASS");
		else
			$display("indexed_min_heap_unit_tb: FAIL");
		$finish;
	end
endmodule
